[sv/swm_pkg.sv]
// ----------------------------------------------------------------------------
// swm_pkg: shared types and constants for the sliding window median
// Holds the neighbor flag bundle passed between sort cells and the
// length register reset value.
// ----------------------------------------------------------------------------
package swm_pkg;

  // window length after reset, before clamping to the cell count
  localparam int LEN_RESET = 5;

  // width of the window length write data field (cfg_wdata)
  localparam int CFG_WIDTH = 5;

  // flags a cell shows to its neighbors
  typedef struct packed {
    logic valid;  // cell is inside the active window
    logic gt;     // cell value is greater than the incoming sample
  } cell_flag_t;

endpackage

[sv/swm_cell.sv]
// ----------------------------------------------------------------------------
// swm_cell: one slot of the sorted window
// Holds one sample and its age. On each beat it drops out if it is the
// oldest, takes a neighbor's value to close or open a gap, or takes the
// incoming sample, so the row stays sorted ascending.
// ----------------------------------------------------------------------------
module swm_cell #(
  parameter int W   = 32,
  parameter int AW  = 4,
  parameter int IDX = 0
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  flush,
  input  logic                  shift,
  input  logic signed [W-1:0]   new_sample,
  input  logic [AW-1:0]         old_age,
  input  logic                  active,
  input  logic signed [W-1:0]   left_val,
  input  logic [AW-1:0]         left_age,
  input  swm_pkg::cell_flag_t   left_flag,
  input  logic signed [W-1:0]   right_val,
  input  logic [AW-1:0]         right_age,
  input  swm_pkg::cell_flag_t   right_flag,
  input  logic                  del_in,
  output logic                  del_out,
  output logic                  is_old,
  output logic signed [W-1:0]   val_o,
  output logic [AW-1:0]         age_o,
  output swm_pkg::cell_flag_t   flag_o
);

  localparam logic [AW-1:0] AGE_INIT = AW'(IDX);

  logic signed [W-1:0] val_r, val_nxt;
  logic [AW-1:0]       age_r, age_nxt;
  logic                gt;
  logic                past_del;
  logic                right_le;

  // own compare and the oldest-entry marker
  assign gt       = val_r > new_sample;
  assign is_old   = active && (age_r == old_age);
  assign past_del = del_in | is_old;
  assign del_out  = past_del;
  assign right_le = right_flag.valid && !right_flag.gt;

  // pick the next content of this slot
  always_comb begin
    val_nxt = val_r;
    age_nxt = age_r + 1'b1;
    if (past_del) begin
      // removed entry at or below this slot: row closes toward it
      if (right_le) begin
        val_nxt = right_val;
        age_nxt = right_age + 1'b1;
      end else if (is_old) begin
        if (!left_flag.valid || !left_flag.gt) begin
          val_nxt = new_sample;
          age_nxt = '0;
        end else begin
          val_nxt = left_val;
          age_nxt = left_age + 1'b1;
        end
      end else if (!gt) begin
        val_nxt = new_sample;
        age_nxt = '0;
      end
    end else begin
      // removed entry above this slot: row opens for the new sample
      if (!gt) begin
        val_nxt = val_r;
      end else if (!left_flag.valid || !left_flag.gt) begin
        val_nxt = new_sample;
        age_nxt = '0;
      end else begin
        val_nxt = left_val;
        age_nxt = left_age + 1'b1;
      end
    end
  end

  // slot storage
  always_ff @(posedge clk) begin
    if (!rst_n || flush) begin
      val_r <= '0;
      age_r <= AGE_INIT;
    end else if (shift) begin
      val_r <= val_nxt;
      age_r <= age_nxt;
    end
  end

  assign val_o        = val_r;
  assign age_o        = age_r;
  assign flag_o.valid = active;
  assign flag_o.gt    = gt;

endmodule

[sv/sliding_window_median.sv]
// Output: a median moves from the cell row into the output register once that
// register is free, and is then offered on out_valid.
// Throughput: one sample per cycle; each sort cell removes the oldest entry
// and inserts the new one on the same shift across the whole cell row. A
// sample beat waits only while the output register holds an untaken median
// and the cell row holds another window whose median is not yet taken.
// Reset: synchronous active-low; window cleared to zero, length set to 5
// (clamped to MAX_WINDOW). A length write clears the window the same way.
// ----------------------------------------------------------------------------
// sliding_window_median: running median over the last window_len samples
// A row of sort cells keeps the window in ascending order with an age tag
// per entry; the median is read from the middle cell into an output stage.
// ----------------------------------------------------------------------------
module sliding_window_median #(
  parameter int MAX_WINDOW   = 16,
  parameter int SAMPLE_WIDTH = 32
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic signed [SAMPLE_WIDTH-1:0]    in_sample,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic signed [SAMPLE_WIDTH-1:0]    out_median,
  input  logic                              cfg_we,
  input  logic [swm_pkg::CFG_WIDTH-1:0]     cfg_wdata
);

  localparam int W  = SAMPLE_WIDTH;
  localparam int AW = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
  localparam int LW = $clog2(MAX_WINDOW + 1);
  localparam int LEN_INIT = (swm_pkg::LEN_RESET > MAX_WINDOW) ? MAX_WINDOW
                                                              : swm_pkg::LEN_RESET;

  logic [LW-1:0]       len_r, len_nxt;
  logic [LW-1:0]       len_m1;
  logic [AW-1:0]       mid_idx;
  logic                pend_r;
  logic                out_valid_r;
  logic signed [W-1:0] out_median_r;
  logic                in_fire;
  logic                out_free;
  logic [31:0]         cfg_ext;

  logic signed [W-1:0]  cell_val  [MAX_WINDOW];
  logic [AW-1:0]        cell_age  [MAX_WINDOW];
  swm_pkg::cell_flag_t  cell_flag [MAX_WINDOW];
  logic [MAX_WINDOW:0]  del_chain;
  logic [MAX_WINDOW-1:0] old_vec;
  logic [MAX_WINDOW-1:0] sorted_ok;

  // length register with clamping
  assign cfg_ext = {{(32 - swm_pkg::CFG_WIDTH){1'b0}}, cfg_wdata};
  always_comb begin
    if (cfg_wdata == '0) begin
      len_nxt = LW'(1);
    end else if (cfg_ext > 32'(MAX_WINDOW)) begin
      len_nxt = LW'(MAX_WINDOW);
    end else begin
      len_nxt = cfg_ext[LW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r <= LW'(LEN_INIT);
    end else if (cfg_we) begin
      len_r <= len_nxt;
    end
  end

  assign len_m1  = len_r - 1'b1;
  assign mid_idx = AW'(len_r >> 1);

  // handshake: a beat enters unless a finished median is stuck behind
  assign out_free = !out_valid_r || out_ready;
  assign in_ready = !pend_r || out_free;
  assign in_fire  = in_valid && in_ready;

  // cell row
  assign del_chain[0] = 1'b0;

  for (genvar i = 0; i < MAX_WINDOW; i++) begin : g_row
    localparam logic [LW-1:0] IDX_L = LW'(i);
    logic signed [W-1:0]  l_val;
    logic [AW-1:0]        l_age;
    swm_pkg::cell_flag_t  l_flag;
    logic signed [W-1:0]  r_val;
    logic [AW-1:0]        r_age;
    swm_pkg::cell_flag_t  r_flag;

    if (i == 0) begin : g_first
      assign l_val  = '0;
      assign l_age  = '0;
      assign l_flag = '0;
    end else begin : g_mid_l
      assign l_val  = cell_val[i-1];
      assign l_age  = cell_age[i-1];
      assign l_flag = cell_flag[i-1];
    end

    if (i == MAX_WINDOW - 1) begin : g_last
      assign r_val  = '0;
      assign r_age  = '0;
      assign r_flag = '0;
    end else begin : g_mid_r
      assign r_val  = cell_val[i+1];
      assign r_age  = cell_age[i+1];
      assign r_flag = cell_flag[i+1];
    end

    swm_cell #(
      .W   (W),
      .AW  (AW),
      .IDX (i)
    ) u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .flush      (cfg_we),
      .shift      (in_fire),
      .new_sample (in_sample),
      .old_age    (len_m1[AW-1:0]),
      .active     (IDX_L < len_r),
      .left_val   (l_val),
      .left_age   (l_age),
      .left_flag  (l_flag),
      .right_val  (r_val),
      .right_age  (r_age),
      .right_flag (r_flag),
      .del_in     (del_chain[i]),
      .del_out    (del_chain[i+1]),
      .is_old     (old_vec[i]),
      .val_o      (cell_val[i]),
      .age_o      (cell_age[i]),
      .flag_o     (cell_flag[i])
    );

    // ordering check between this cell and the next active one
    if (i == MAX_WINDOW - 1) begin : g_ok_last
      assign sorted_ok[i] = 1'b1;
    end else begin : g_ok
      assign sorted_ok[i] = !cell_flag[i+1].valid || (cell_val[i] <= cell_val[i+1]);
    end
  end

  // pending flag: cells hold a fresh window whose median is not yet taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= 1'b0;
    end else if (in_fire) begin
      pend_r <= 1'b1;
    end else if (out_free) begin
      pend_r <= 1'b0;
    end
  end

  // output stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r <= pend_r;
    end
  end

  always_ff @(posedge clk) begin
    if (pend_r && out_free) begin
      out_median_r <= cell_val[mid_idx];
    end
  end

  assign out_valid  = out_valid_r;
  assign out_median = out_median_r;

  // exactly one active entry is the oldest
  a_one_oldest: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot(old_vec))
    else $error("oldest entry not unique");

  // active cells stay in ascending order
  a_sorted: assert property (@(posedge clk) disable iff (!rst_n)
    &sorted_ok)
    else $error("cell row out of order");

  // an accepted sample always leaves a pending median
  a_pend: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> pend_r)
    else $error("accepted sample lost");

  // a pending median moves into a free output stage
  a_move: assert property (@(posedge clk) disable iff (!rst_n)
    (pend_r && !out_valid_r) |=> out_valid_r)
    else $error("pending median not forwarded");

endmodule

[tb/sliding_window_median_test.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sliding_window_median_test: regression bench for the running median
// Sends signed samples through the valid/ready input channel and checks each
// median beat against a typed want or an in-bench window model. Directed
// rows cover sample extremes, length clamping, window clears and the upper
// middle pick for even lengths. Random phases each start with a length write.
// ----------------------------------------------------------------------------
module sliding_window_median_test;

  localparam int MAX_WINDOW   = 16;
  localparam int SAMPLE_WIDTH = 32;
  localparam int RANDOM_ITEMS = 800;
  localparam int SETTLE_CYCLES = 6;
  localparam int CYCLE_LIMIT  = 300000;

  typedef logic signed [SAMPLE_WIDTH-1:0] sample_t;

  // directed table rows: either a sample beat or a length write
  typedef enum logic {ROW_SAMPLE, ROW_LEN_WRITE} row_kind_t;

  typedef struct packed {
    row_kind_t         kind;
    logic [31:0]       value;
    logic              typed;  // want holds a hand-computed median
    logic [31:0]       want;
  } stim_row_t;

  localparam int N_DIRECTED = 26;

  stim_row_t directed_rows [N_DIRECTED] = '{
    // length 5 after reset, mostly zeros in the window
    '{ROW_SAMPLE,    32'h7FFF_FFFF, 1'b1, 32'h0000_0000},
    '{ROW_SAMPLE,    32'h8000_0000, 1'b1, 32'h0000_0000},
    '{ROW_SAMPLE,    32'h0000_0001, 1'b1, 32'h0000_0000},
    '{ROW_SAMPLE,    32'hFFFF_FFFF, 1'b0, 32'h0},
    '{ROW_SAMPLE,    32'h7FFF_FFFF, 1'b0, 32'h0},
    '{ROW_SAMPLE,    32'h8000_0000, 1'b0, 32'h0},
    // length zero is raised to one: median is the sample itself
    '{ROW_LEN_WRITE, 32'h0000_0000, 1'b0, 32'h0},
    '{ROW_SAMPLE,    32'hFFFF_FFFF, 1'b1, 32'hFFFF_FFFF},
    '{ROW_SAMPLE,    32'h8000_0000, 1'b1, 32'h8000_0000},
    '{ROW_SAMPLE,    32'h7FFF_FFFF, 1'b1, 32'h7FFF_FFFF},
    // all ones saturates to the full window, cleared to zero
    '{ROW_LEN_WRITE, 32'h0000_001F, 1'b0, 32'h0},
    '{ROW_SAMPLE,    32'h7FFF_FFFF, 1'b1, 32'h0000_0000},
    '{ROW_SAMPLE,    32'h8000_0000, 1'b1, 32'h0000_0000},
    '{ROW_SAMPLE,    32'h1234_5678, 1'b1, 32'h0000_0000},
    // even length picks the upper middle
    '{ROW_LEN_WRITE, 32'h0000_0002, 1'b0, 32'h0},
    '{ROW_SAMPLE,    32'h0000_0003, 1'b1, 32'h0000_0003},
    '{ROW_SAMPLE,    32'hFFFF_FFFD, 1'b1, 32'h0000_0003},
    '{ROW_SAMPLE,    32'hAAAA_AAAA, 1'b0, 32'h0},
    '{ROW_LEN_WRITE, 32'h0000_0010, 1'b0, 32'h0},
    '{ROW_SAMPLE,    32'h5555_5555, 1'b1, 32'h0000_0000},
    // just above the cell count
    '{ROW_LEN_WRITE, 32'h0000_0011, 1'b0, 32'h0},
    '{ROW_SAMPLE,    32'hFFFF_FFFF, 1'b1, 32'h0000_0000},
    '{ROW_LEN_WRITE, 32'h0000_0003, 1'b0, 32'h0},
    '{ROW_SAMPLE,    32'h0000_0005, 1'b0, 32'h0},
    '{ROW_SAMPLE,    32'h0000_0005, 1'b0, 32'h0},
    '{ROW_LEN_WRITE, 32'h0000_0005, 1'b0, 32'h0}
  };

  logic                          clk;
  logic                          rst_n;
  logic                          in_valid;
  logic                          in_ready;
  sample_t                       in_sample;
  logic                          out_valid;
  logic                          out_ready;
  sample_t                       out_median;
  logic                          cfg_we;
  logic [swm_pkg::CFG_WIDTH-1:0] cfg_wdata;

  // window model and pending medians
  sample_t track_window [MAX_WINDOW];
  int      track_len;
  sample_t median_expected_q [$];

  int error_count;
  bit no_idle;
  int ready_hold;

  sliding_window_median #(
    .MAX_WINDOW   (MAX_WINDOW),
    .SAMPLE_WIDTH (SAMPLE_WIDTH)
  ) u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_sample  (in_sample),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_median (out_median),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata)
  );

  // 8 ns clock
  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  // clamp the written length and clear the window
  function automatic void apply_window_len(logic [swm_pkg::CFG_WIDTH-1:0] value);
    int len_v;
    len_v = int'(value);
    if (len_v < 1) len_v = 1;
    if (len_v > MAX_WINDOW) len_v = MAX_WINDOW;
    track_len = len_v;
    foreach (track_window[i]) track_window[i] = '0;
  endfunction

  // shift the sample in and return the sorted middle entry
  function automatic sample_t shift_in_median(sample_t sample);
    sample_t ordered [MAX_WINDOW];
    sample_t v;
    int      j;
    for (int i = 0; i + 1 < track_len; i++) track_window[i] = track_window[i + 1];
    track_window[track_len - 1] = sample;
    for (int i = 0; i < track_len; i++) begin
      v = track_window[i];
      j = i;
      while (j > 0 && ordered[j - 1] > v) begin
        ordered[j] = ordered[j - 1];
        j--;
      end
      ordered[j] = v;
    end
    return ordered[track_len / 2];
  endfunction

  // idle length: mostly none or short, now and then long
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (no_idle || r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(5, 30);
  endfunction

  function automatic sample_t pick_sample(int mode);
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) begin
      case ($urandom_range(0, 4))
        0: return 32'sh8000_0000;
        1: return 32'sh7FFF_FFFF;
        2: return -32'sd1;
        3: return 32'sd0;
        default: return 32'sd1;
      endcase
    end
    case (mode)
      // narrow range around zero gives plenty of ties
      1: return sample_t'($urandom_range(0, 14)) - 32'sd7;
      // clustered at the top and bottom of the range
      2: return ($urandom_range(0, 1) ? 32'sh7FFF_FF00 : 32'sh8000_0000)
                | sample_t'($urandom_range(0, 255));
      3: return sample_t'($signed(16'($urandom)));
      default: return sample_t'($urandom);
    endcase
  endfunction

  function automatic logic [swm_pkg::CFG_WIDTH-1:0] pick_len_code();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return swm_pkg::CFG_WIDTH'($urandom_range(MAX_WINDOW + 1, 31));
      2: return swm_pkg::CFG_WIDTH'(MAX_WINDOW);
      3: return swm_pkg::CFG_WIDTH'(1);
      default: return swm_pkg::CFG_WIDTH'($urandom_range(1, MAX_WINDOW));
    endcase
  endfunction

  task automatic report_mismatch(string what, sample_t got, sample_t want);
    $display("mismatch %s: got %0d (0x%08h) want %0d (0x%08h) at %0t",
             what, got, got, want, want, $realtime);
    error_count++;
  endtask

  // one sample beat; returns at the accepting edge with in_valid still high
  task automatic send_sample(sample_t value, logic typed, sample_t want);
    int      gap;
    sample_t predicted;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid  <= 1'b1;
    in_sample <= value;
    do @(negedge clk); while (!in_ready);
    @(posedge clk);
    predicted = shift_in_median(value);
    median_expected_q.push_back(typed ? want : predicted);
  endtask

  // length write once the pipe has drained
  task automatic write_len(logic [swm_pkg::CFG_WIDTH-1:0] value);
    in_valid <= 1'b0;
    while (median_expected_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    apply_window_len(value);
  endtask

  // result side stalls
  always @(posedge clk) begin
    if (!rst_n || no_idle) begin
      out_ready  <= 1'b1;
      ready_hold <= 0;
    end else if (ready_hold > 0) begin
      ready_hold <= ready_hold - 1;
    end else if (out_ready) begin
      if ($urandom_range(0, 3) == 0) begin
        out_ready  <= 1'b0;
        ready_hold <= pick_gap();
      end
    end else begin
      out_ready  <= 1'b1;
      ready_hold <= $urandom_range(0, 12);
    end
  end

  // median beat check, sampled mid-cycle before the accepting edge
  always @(negedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (median_expected_q.size() == 0) begin
        report_mismatch("unexpected beat", out_median, 'x);
      end else if (out_median !== median_expected_q[0]) begin
        report_mismatch("median", out_median, median_expected_q[0]);
        void'(median_expected_q.pop_front());
      end else begin
        void'(median_expected_q.pop_front());
      end
    end
  end

  // cycle watchdog
  initial begin : watchdog
    for (int cycle_count = 0; cycle_count < CYCLE_LIMIT; cycle_count++) @(posedge clk);
    $display("sliding_window_median regression: fail");
    $finish;
  end

  // stimulus
  initial begin : stimulus
    int sent;
    int count;
    int mode;
    no_idle     = 1'b0;
    rst_n     <= 1'b0;
    in_valid  <= 1'b0;
    in_sample <= '0;
    cfg_we    <= 1'b0;
    cfg_wdata <= '0;
    foreach (track_window[i]) track_window[i] = '0;
    track_len = (swm_pkg::LEN_RESET > MAX_WINDOW) ? MAX_WINDOW : swm_pkg::LEN_RESET;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed table
    foreach (directed_rows[i]) begin
      if (directed_rows[i].kind == ROW_LEN_WRITE)
        write_len(directed_rows[i].value[swm_pkg::CFG_WIDTH-1:0]);
      else
        send_sample(directed_rows[i].value, directed_rows[i].typed, directed_rows[i].want);
    end

    // random phases, each with a fresh length
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      write_len(pick_len_code());
      no_idle = ($urandom_range(0, 4) == 0);
      count   = $urandom_range(20, 90);
      mode    = $urandom_range(0, 3);
      for (int k = 0; k < count; k++) send_sample(pick_sample(mode), 1'b0, '0);
      sent += count;
    end
    no_idle = 1'b0;

    // drain
    in_valid <= 1'b0;
    while (median_expected_q.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (error_count == 0) begin
      $display("sliding_window_median regression: pass");
    end else begin
      $display("sliding_window_median regression: fail");
    end
    $finish;
  end

endmodule

[sim.f]
sv/swm_pkg.sv
sv/swm_cell.sv
sv/sliding_window_median.sv
tb/sliding_window_median_test.sv
